>>> src/dxt5_pkg.sv
package dxt5_pkg;

  localparam int MAX_DIMENSION = 4096;
  localparam int DIM_W   = 13;
  localparam int COORD_W = 12;
  localparam int BLK_W   = $clog2(MAX_DIMENSION / 4);
  localparam int CFG_IDX_W = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [7:0]  alpha_end0;
    logic [7:0]  alpha_end1;
    logic [47:0] alpha_indices;
    logic [15:0] color_end0;
    logic [15:0] color_end1;
    logic [31:0] color_indices;
  } in_item_t;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [31:0] pixel_rgba;
    logic        block_last;
    logic        image_last;
  } out_item_t;

  // One decoded block waiting for the pixel sequencer
  typedef struct packed {
    logic [3:0][23:0] colour;
    logic [7:0][7:0]  alpha;
    logic [31:0]      color_indices;
    logic [47:0]      alpha_indices;
    logic [BLK_W-1:0] block_column;
    logic [BLK_W-1:0] block_row;
    logic [1:0]       ncol_m1;
    logic [1:0]       nrow_m1;
    logic             last_block;
  } blk_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    widen5 = {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    widen6 = {v, v[5:4]};
  endfunction

  // Exact floor(x/3) for x < 768
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [20:0] p;
    p = {11'd0, x} * 21'd683;
    div3 = p[18:11];
  endfunction

  // Exact floor(x/7) for x < 1792
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd2341;
    div7 = p[21:14];
  endfunction

  // Exact floor(x/5) for x < 1280
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [22:0] p;
    p = {12'd0, x} * 23'd3277;
    div5 = p[21:14];
  endfunction

endpackage

>>> src/dxt5_block_decoder_top.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------------
// input    | in_valid / in_ready  | in_data   : one DXT5 block (in_item_t)
// result   | out_valid/out_ready  | out_data  : one RGBA8 pixel (out_item_t)
// config   | cfg_valid/cfg_ready  | cfg_index, cfg_data : register write
//
// A full block yields 16 pixel transfers, one per cycle while the output is not
// stalled; an edge block yields (columns inside) x (rows inside) transfers.
// The pixel sequencer sets the block throughput.
// The palettes are built as a block is taken in, and a two-entry queue holds
// decoded blocks, so input continues while the result side stalls until full.
// Synchronous active-low reset: dimensions return to 4096, block counters to
// 0,0, queue and output register empty. cfg_ready is always high.
module dxt5_block_decoder_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dxt5_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output dxt5_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dxt5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dxt5_pkg::DIM_W-1:0]      cfg_data
);

  logic           push;
  dxt5_pkg::blk_t push_data;
  logic           queue_full;
  logic           pop;
  dxt5_pkg::blk_t head;
  logic           head_valid;

  // Front: take blocks in, build palettes, track block position
  dxt5_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .queue_full(queue_full),
    .push      (push),
    .push_data (push_data)
  );

  // Hold decoded blocks between the two sides
  dxt5_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(push_data),
    .full     (queue_full),
    .pop      (pop),
    .head     (head),
    .not_empty(head_valid)
  );

  // Back: emit the clipped pixels of the head block through the output register
  dxt5_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .blk_valid(head_valid),
    .blk      (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

>>> src/dxt5_front.sv
module dxt5_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  dxt5_pkg::in_item_t              in_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dxt5_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dxt5_pkg::DIM_W-1:0]      cfg_data,
  input  logic                            queue_full,
  output logic                            push,
  output dxt5_pkg::blk_t                  push_data
);

  logic [dxt5_pkg::DIM_W-1:0] width_r, width_nxt;
  logic [dxt5_pkg::DIM_W-1:0] height_r, height_nxt;
  logic [dxt5_pkg::BLK_W-1:0] col_r, col_nxt;
  logic [dxt5_pkg::BLK_W-1:0] row_r, row_nxt;

  logic [dxt5_pkg::DIM_W-1:0] w_clamp, h_clamp;
  logic [dxt5_pkg::DIM_W-1:0] w_blk, h_blk;
  logic [dxt5_pkg::BLK_W:0]   bw, bh;
  logic                       col_end, row_end;
  logic [dxt5_pkg::DIM_W-1:0] rem_x, rem_y;

  logic [3:0][7:0] r, g, b;
  logic [7:0][7:0] alpha;
  logic [7:0]      a0, a1;
  logic [10:0]     asum;

  assign cfg_ready = 1'b1;
  assign in_ready  = !queue_full;
  assign push      = in_valid && in_ready;

  // Clamp dimensions: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (width_r == '0) w_clamp = dxt5_pkg::DIM_W'(1);
    else if (width_r > dxt5_pkg::DIM_W'(dxt5_pkg::MAX_DIMENSION))
      w_clamp = dxt5_pkg::DIM_W'(dxt5_pkg::MAX_DIMENSION);
    else w_clamp = width_r;
    if (height_r == '0) h_clamp = dxt5_pkg::DIM_W'(1);
    else if (height_r > dxt5_pkg::DIM_W'(dxt5_pkg::MAX_DIMENSION))
      h_clamp = dxt5_pkg::DIM_W'(dxt5_pkg::MAX_DIMENSION);
    else h_clamp = height_r;
  end

  assign w_blk = (w_clamp + dxt5_pkg::DIM_W'(3)) >> 2;
  assign h_blk = (h_clamp + dxt5_pkg::DIM_W'(3)) >> 2;
  assign bw = w_blk[dxt5_pkg::BLK_W:0];
  assign bh = h_blk[dxt5_pkg::BLK_W:0];
  assign col_end = ({1'b0, col_r} + (dxt5_pkg::BLK_W+1)'(1)) >= bw;
  assign row_end = ({1'b0, row_r} + (dxt5_pkg::BLK_W+1)'(1)) >= bh;

  assign rem_x = w_clamp - {1'b0, col_r, 2'b00};
  assign rem_y = h_clamp - {1'b0, row_r, 2'b00};

  // Colour palette
  always_comb begin
    r[0] = dxt5_pkg::widen5(in_data.color_end0[15:11]);
    g[0] = dxt5_pkg::widen6(in_data.color_end0[10:5]);
    b[0] = dxt5_pkg::widen5(in_data.color_end0[4:0]);
    r[1] = dxt5_pkg::widen5(in_data.color_end1[15:11]);
    g[1] = dxt5_pkg::widen6(in_data.color_end1[10:5]);
    b[1] = dxt5_pkg::widen5(in_data.color_end1[4:0]);
    r[2] = dxt5_pkg::div3({1'b0, r[0], 1'b0} + {2'b0, r[1]});
    r[3] = dxt5_pkg::div3({2'b0, r[0]} + {1'b0, r[1], 1'b0});
    g[2] = dxt5_pkg::div3({1'b0, g[0], 1'b0} + {2'b0, g[1]});
    g[3] = dxt5_pkg::div3({2'b0, g[0]} + {1'b0, g[1], 1'b0});
    b[2] = dxt5_pkg::div3({1'b0, b[0], 1'b0} + {2'b0, b[1]});
    b[3] = dxt5_pkg::div3({2'b0, b[0]} + {1'b0, b[1], 1'b0});
  end

  // Alpha palette: six-step or four-step with fixed 0 and 255
  always_comb begin
    a0 = in_data.alpha_end0;
    a1 = in_data.alpha_end1;
    alpha[0] = a0;
    alpha[1] = a1;
    asum = '0;
    if (a0 > a1) begin
      for (int k = 1; k <= 6; k++) begin
        asum = {3'd0, a0} * 11'(7 - k) + {3'd0, a1} * 11'(k);
        alpha[k + 1] = dxt5_pkg::div7(asum);
      end
    end else begin
      for (int k = 1; k <= 4; k++) begin
        asum = {3'd0, a0} * 11'(5 - k) + {3'd0, a1} * 11'(k);
        alpha[k + 1] = dxt5_pkg::div5(asum);
      end
      alpha[6] = 8'd0;
      alpha[7] = 8'd255;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) push_data.colour[k] = {b[k], g[k], r[k]};
    push_data.alpha         = alpha;
    push_data.color_indices = in_data.color_indices;
    push_data.alpha_indices = in_data.alpha_indices;
    push_data.block_column  = col_r;
    push_data.block_row     = row_r;
    push_data.ncol_m1 = (rem_x >= dxt5_pkg::DIM_W'(4)) ? 2'd3 : 2'(rem_x - dxt5_pkg::DIM_W'(1));
    push_data.nrow_m1 = (rem_y >= dxt5_pkg::DIM_W'(4)) ? 2'd3 : 2'(rem_y - dxt5_pkg::DIM_W'(1));
    push_data.last_block = col_end && row_end;
  end

  // Block counters and dimension registers
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (cfg_valid && cfg_ready &&
        (cfg_index == dxt5_pkg::REG_IMAGE_WIDTH || cfg_index == dxt5_pkg::REG_IMAGE_HEIGHT)) begin
      if (cfg_index == dxt5_pkg::REG_IMAGE_WIDTH) width_nxt = cfg_data;
      else height_nxt = cfg_data;
      col_nxt = '0;
      row_nxt = '0;
    end else if (push) begin
      if (col_end) begin
        col_nxt = '0;
        row_nxt = row_end ? '0 : row_r + dxt5_pkg::BLK_W'(1);
      end else begin
        col_nxt = col_r + dxt5_pkg::BLK_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dxt5_pkg::DIM_W'(dxt5_pkg::MAX_DIMENSION);
      height_r <= dxt5_pkg::DIM_W'(dxt5_pkg::MAX_DIMENSION);
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

endmodule

>>> src/dxt5_queue.sv
module dxt5_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dxt5_pkg::blk_t push_data,
  output logic           full,
  input  logic           pop,
  output dxt5_pkg::blk_t head,
  output logic           not_empty
);

  localparam int PTR_W = $clog2(dxt5_pkg::QUEUE_DEPTH);

  dxt5_pkg::blk_t entry_r [dxt5_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full      = count_r == (PTR_W+1)'(dxt5_pkg::QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign head      = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    if (pop)  rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    if (push && !pop) count_nxt = count_r + (PTR_W+1)'(1);
    else if (pop && !push) count_nxt = count_r - (PTR_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> src/dxt5_back.sv
module dxt5_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                blk_valid,
  input  dxt5_pkg::blk_t      blk,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output dxt5_pkg::out_item_t out_data
);

  logic [1:0] px_r, px_nxt;
  logic [1:0] py_r, py_nxt;
  logic       out_valid_r, out_valid_nxt;
  dxt5_pkg::out_item_t out_data_r, out_data_nxt;

  logic       advance;
  logic [3:0] pix;
  logic [1:0] ci;
  logic [2:0] ai;
  logic       blk_end;

  assign advance = blk_valid && (!out_valid_r || out_ready);
  assign pix     = {py_r, px_r};
  assign ci      = blk.color_indices[{pix, 1'b0} +: 2];
  assign ai      = blk.alpha_indices[6'(pix) * 6'd3 +: 3];
  assign blk_end = (px_r == blk.ncol_m1) && (py_r == blk.nrow_m1);
  assign pop     = advance && blk_end;

  always_comb begin
    px_nxt        = px_r;
    py_nxt        = py_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (advance) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.pixel_x    = {blk.block_column, px_r};
      out_data_nxt.pixel_y    = {blk.block_row, py_r};
      out_data_nxt.pixel_rgba = {blk.alpha[ai], blk.colour[ci]};
      out_data_nxt.block_last = blk_end;
      out_data_nxt.image_last = blk_end && blk.last_block;
      // Walk only the pixels inside the image, row by row
      if (blk_end) begin
        px_nxt = '0;
        py_nxt = '0;
      end else if (px_r == blk.ncol_m1) begin
        px_nxt = '0;
        py_nxt = py_r + 2'd1;
      end else begin
        px_nxt = px_r + 2'd1;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r        <= '0;
      py_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      px_r        <= px_nxt;
      py_r        <= py_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
